/* hw/rtl/arm_pid_pkg.sv */
`timescale 1ns / 1ps

package arm_pid_pkg;

    // Field and register widths.
    localparam int GAIN_W    = 40;
    localparam int HALF_W    = 20;   // gains and the error-sum magnitude are split in two halves
    localparam int ZONE_W    = 18;
    localparam int FLOOR_W   = 16;
    localparam int OFFS_W    = 11;
    localparam int POS_W     = 18;
    localparam int ERR_W     = 19;
    localparam int DELTA_W   = 20;
    localparam int SUM_W     = 40;
    localparam int DRIVE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 40;   // position, target, button_up, button_down, pad

    // Full product width: wide enough that the saturation bit still lies inside
    // the word after the largest fractional shift.
    localparam int PROD_W       = 88;
    localparam int TERM_LIM_BIT = 47;
    localparam int TERM_W       = TERM_LIM_BIT + 2;
    localparam int POWER_W      = TERM_W + 2;

    localparam logic [TERM_W-1:0] TERM_LIM = {2'b01, {TERM_LIM_BIT{1'b0}}};

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // Manual drive step for one pressed button.
    localparam logic signed [POWER_W-1:0] MANUAL_STEP = 51'sd127;

    // Register reset values.
    localparam logic [GAIN_W-1:0]         GAIN_UP_RST         = 40'd214748365;
    localparam logic [GAIN_W-1:0]         GAIN_DOWN_RST       = 40'd214748365;
    localparam logic [GAIN_W-1:0]         GAIN_INTEGRAL_RST   = 40'd644;
    localparam logic [GAIN_W-1:0]         GAIN_DERIVATIVE_RST = 40'd2147483648;
    localparam logic [ZONE_W-1:0]         ZONE_LOW_RST        = 18'd100;
    localparam logic [ZONE_W-1:0]         ZONE_HIGH_RST       = 18'd2000;
    localparam logic signed [FLOOR_W-1:0] DRIVE_FLOOR_RST     = -16'sd800;
    localparam logic signed [OFFS_W-1:0]  FEED_OFFSET_RST     = 11'sd20;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_UP         = 3'd0,
        REG_GAIN_DOWN       = 3'd1,
        REG_GAIN_INTEGRAL   = 3'd2,
        REG_GAIN_DERIVATIVE = 3'd3,
        REG_ZONE_LOW        = 3'd4,
        REG_ZONE_HIGH       = 3'd5,
        REG_DRIVE_FLOOR     = 3'd6,
        REG_FEED_OFFSET     = 3'd7
    } cfg_reg_t;

endpackage

/* hw/rtl/arm_position_pid_top.sv */
`timescale 1ns / 1ps

// Arm position PID loop. Each input transaction is one control tick carrying
// the measured position, the target position, the manual-mode flag and the
// two manual buttons; each tick yields exactly one drive transaction. The
// block takes a new tick in every cycle while s_tready is high. The accepting
// edge updates the error sum and the previous error and loads the product
// operands into stage 1; stage 2 forms the partial products of the three
// gain multiplies, stage 3 assembles and scales them, stage 4 adds the
// terms, and the output register takes the floor, the offset removal and
// the saturation and offers the drive. Ready drops only when every stage
// holds a tick and the output is stalled. Gains are unsigned fixed point
// with FRAC_BITS fraction bits; products are floored. Configuration
// registers are written through cfg_we / cfg_index / cfg_wdata and should
// only be changed while no tick is in flight. No clearing pass is needed
// after reset.
module arm_position_pid_top
    import arm_pid_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_wdata,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [17:0] position, [35:18] target, [36] button_up, [37] button_down,
    // [39:38] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] manual_mode
    input  logic                 s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] drive
    output logic [DRIVE_W-1:0]   m_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]         gain_up_reg;
    logic [GAIN_W-1:0]         gain_down_reg;
    logic [GAIN_W-1:0]         gain_integral_reg;
    logic [GAIN_W-1:0]         gain_derivative_reg;
    logic [ZONE_W-1:0]         zone_low_reg;
    logic [ZONE_W-1:0]         zone_high_reg;
    logic signed [FLOOR_W-1:0] drive_floor_reg;
    logic signed [OFFS_W-1:0]  feed_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_up_reg         <= GAIN_UP_RST;
            gain_down_reg       <= GAIN_DOWN_RST;
            gain_integral_reg   <= GAIN_INTEGRAL_RST;
            gain_derivative_reg <= GAIN_DERIVATIVE_RST;
            zone_low_reg        <= ZONE_LOW_RST;
            zone_high_reg       <= ZONE_HIGH_RST;
            drive_floor_reg     <= DRIVE_FLOOR_RST;
            feed_offset_reg     <= FEED_OFFSET_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_UP:         gain_up_reg         <= cfg_wdata;
                REG_GAIN_DOWN:       gain_down_reg       <= cfg_wdata;
                REG_GAIN_INTEGRAL:   gain_integral_reg   <= cfg_wdata;
                REG_GAIN_DERIVATIVE: gain_derivative_reg <= cfg_wdata;
                REG_ZONE_LOW:        zone_low_reg        <= cfg_wdata[ZONE_W-1:0];
                REG_ZONE_HIGH:       zone_high_reg       <= cfg_wdata[ZONE_W-1:0];
                REG_DRIVE_FLOOR:     drive_floor_reg     <= cfg_wdata[FLOOR_W-1:0];
                REG_FEED_OFFSET:     feed_offset_reg     <= cfg_wdata[OFFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it moves on, so bubbles are squeezed out even while the
    // output waits.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;
    logic in_fire;

    assign rdy_out  = !out_valid_reg || m_tready;
    assign rdy4     = !v4_reg || rdy_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign in_fire  = s_tvalid && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy_out) begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept cycle: error, error change and the running sum. The sum and
    // the previous error update on every accepted tick, in manual mode too.
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0]   in_position;
    logic signed [POS_W-1:0]   in_target;
    logic signed [ERR_W-1:0]   err_in;
    logic signed [DELTA_W-1:0] delta_in;
    logic [ERR_W-1:0]          err_mag_in;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic                      zone_clear;
    logic signed [SUM_W-1:0]   error_sum_next;

    logic signed [ERR_W-1:0]   previous_error_reg;
    logic signed [SUM_W-1:0]   error_sum_reg;

    assign in_position = s_tdata[POS_W-1:0];
    assign in_target   = s_tdata[2*POS_W-1:POS_W];

    assign err_in   = {in_target[POS_W-1], in_target} - {in_position[POS_W-1], in_position};
    assign delta_in = {err_in[ERR_W-1], err_in}
                    - {previous_error_reg[ERR_W-1], previous_error_reg};
    assign err_mag_in = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);

    assign sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                    + {{(SUM_W+1-ERR_W){err_in[ERR_W-1]}}, err_in};

    always_comb begin
        // Overflow shows as the two top bits of the widened sum disagreeing.
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Both zone tests apply on their own, even when the zones cross.
    assign zone_clear = (err_mag_in < {1'b0, zone_low_reg})
                     || (err_mag_in > {1'b0, zone_high_reg});
    assign error_sum_next = zone_clear ? '0 : sum_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_error_reg <= '0;
            error_sum_reg      <= '0;
        end else if (in_fire) begin
            previous_error_reg <= err_in;
            error_sum_reg      <= error_sum_next;
        end
    end

    // Stage 1 holds the signed operands of the three products.
    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [DELTA_W-1:0] s1_delta_reg;
    logic signed [SUM_W-1:0]   s1_sum_reg;
    logic                      s1_manual_reg, s1_up_reg, s1_down_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_err_reg    <= err_in;
            s1_delta_reg  <= delta_in;
            s1_sum_reg    <= error_sum_next;
            s1_manual_reg <= s_tuser;
            s1_up_reg     <= s_tdata[2*POS_W];
            s1_down_reg   <= s_tdata[2*POS_W+1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes times gain halves. The widest partial product is
    // 20 by 20 bits.
    // ------------------------------------------------------------------
    logic [ERR_W-1:0]   e_mag;
    logic [DELTA_W-1:0] d_mag;
    logic [SUM_W-1:0]   i_mag;
    logic               err_pos;
    logic [GAIN_W-1:0]  gain_p;

    assign e_mag   = s1_err_reg[ERR_W-1] ? ERR_W'(-s1_err_reg) : ERR_W'(s1_err_reg);
    assign d_mag   = s1_delta_reg[DELTA_W-1] ? DELTA_W'(-s1_delta_reg) : DELTA_W'(s1_delta_reg);
    assign i_mag   = s1_sum_reg[SUM_W-1] ? SUM_W'(-s1_sum_reg) : SUM_W'(s1_sum_reg);
    assign err_pos = !s1_err_reg[ERR_W-1] && (s1_err_reg != '0);
    assign gain_p  = err_pos ? gain_up_reg : gain_down_reg;

    logic [ERR_W+HALF_W-1:0] s2_pe_lo_reg, s2_pe_hi_reg;
    logic [2*HALF_W-1:0]     s2_pd_lo_reg, s2_pd_hi_reg;
    logic [2*HALF_W-1:0]     s2_pi_ll_reg, s2_pi_lh_reg, s2_pi_hl_reg, s2_pi_hh_reg;
    logic                    s2_err_neg_reg, s2_delta_neg_reg, s2_sum_neg_reg;
    logic                    s2_manual_reg, s2_up_reg, s2_down_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_pe_lo_reg <= {{HALF_W{1'b0}}, e_mag} * {{ERR_W{1'b0}}, gain_p[HALF_W-1:0]};
            s2_pe_hi_reg <= {{HALF_W{1'b0}}, e_mag} * {{ERR_W{1'b0}}, gain_p[GAIN_W-1:HALF_W]};
            s2_pd_lo_reg <= {{HALF_W{1'b0}}, d_mag}
                          * {{HALF_W{1'b0}}, gain_derivative_reg[HALF_W-1:0]};
            s2_pd_hi_reg <= {{HALF_W{1'b0}}, d_mag}
                          * {{HALF_W{1'b0}}, gain_derivative_reg[GAIN_W-1:HALF_W]};
            s2_pi_ll_reg <= {{HALF_W{1'b0}}, i_mag[HALF_W-1:0]}
                          * {{HALF_W{1'b0}}, gain_integral_reg[HALF_W-1:0]};
            s2_pi_lh_reg <= {{HALF_W{1'b0}}, i_mag[HALF_W-1:0]}
                          * {{HALF_W{1'b0}}, gain_integral_reg[GAIN_W-1:HALF_W]};
            s2_pi_hl_reg <= {{HALF_W{1'b0}}, i_mag[SUM_W-1:HALF_W]}
                          * {{HALF_W{1'b0}}, gain_integral_reg[HALF_W-1:0]};
            s2_pi_hh_reg <= {{HALF_W{1'b0}}, i_mag[SUM_W-1:HALF_W]}
                          * {{HALF_W{1'b0}}, gain_integral_reg[GAIN_W-1:HALF_W]};
            s2_err_neg_reg   <= s1_err_reg[ERR_W-1];
            s2_delta_neg_reg <= s1_delta_reg[DELTA_W-1];
            s2_sum_neg_reg   <= s1_sum_reg[SUM_W-1];
            s2_manual_reg    <= s1_manual_reg;
            s2_up_reg        <= s1_up_reg;
            s2_down_reg      <= s1_down_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: full products, fraction removal with floor, saturation to
    // plus or minus 2^47 and sign restore.
    // ------------------------------------------------------------------
    function automatic logic signed [TERM_W-1:0] scale_term(
        input logic [PROD_W-1:0] prod,
        input logic              neg
    );
        logic [PROD_W-1:0] q;
        logic              rem;
        logic              sat;
        logic [TERM_W-1:0] mag;
        q   = prod >> FRAC_BITS;
        rem = |prod[FRAC_BITS-1:0];
        sat = |q[PROD_W-1:TERM_LIM_BIT];
        // Flooring a negative product moves it one step away from zero
        // whenever nonzero fraction bits are dropped, unless it saturates.
        if (sat) begin
            mag = TERM_LIM;
        end else begin
            mag = {2'b00, q[TERM_LIM_BIT-1:0]} + {{(TERM_W-1){1'b0}}, neg & rem};
        end
        return neg ? TERM_W'(-mag) : mag;
    endfunction

    logic [PROD_W-1:0] pe_full, pd_full, pi_full;

    assign pe_full = {{(PROD_W-ERR_W-HALF_W){1'b0}}, s2_pe_lo_reg}
                   + {{(PROD_W-ERR_W-2*HALF_W){1'b0}}, s2_pe_hi_reg, {HALF_W{1'b0}}};
    assign pd_full = {{(PROD_W-2*HALF_W){1'b0}}, s2_pd_lo_reg}
                   + {{(PROD_W-3*HALF_W){1'b0}}, s2_pd_hi_reg, {HALF_W{1'b0}}};
    assign pi_full = {{(PROD_W-2*HALF_W){1'b0}}, s2_pi_ll_reg}
                   + {{(PROD_W-3*HALF_W){1'b0}}, s2_pi_lh_reg, {HALF_W{1'b0}}}
                   + {{(PROD_W-3*HALF_W){1'b0}}, s2_pi_hl_reg, {HALF_W{1'b0}}}
                   + {{(PROD_W-4*HALF_W){1'b0}}, s2_pi_hh_reg, {(2*HALF_W){1'b0}}};

    logic signed [TERM_W-1:0] s3_tp_reg, s3_ti_reg, s3_td_reg;
    logic                     s3_manual_reg, s3_up_reg, s3_down_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_tp_reg     <= scale_term(pe_full, s2_err_neg_reg);
            s3_ti_reg     <= scale_term(pi_full, s2_sum_neg_reg);
            s3_td_reg     <= scale_term(pd_full, s2_delta_neg_reg);
            s3_manual_reg <= s2_manual_reg;
            s3_up_reg     <= s2_up_reg;
            s3_down_reg   <= s2_down_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: closed-loop power, the three terms plus the feed-forward
    // offset.
    // ------------------------------------------------------------------
    logic signed [POWER_W-1:0] tp_ext, ti_ext, td_ext, offs_ext, power_sum;

    assign tp_ext    = {{(POWER_W-TERM_W){s3_tp_reg[TERM_W-1]}}, s3_tp_reg};
    assign ti_ext    = {{(POWER_W-TERM_W){s3_ti_reg[TERM_W-1]}}, s3_ti_reg};
    assign td_ext    = {{(POWER_W-TERM_W){s3_td_reg[TERM_W-1]}}, s3_td_reg};
    assign offs_ext  = {{(POWER_W-OFFS_W){feed_offset_reg[OFFS_W-1]}}, feed_offset_reg};
    assign power_sum = tp_ext + ti_ext + td_ext + offs_ext;

    logic signed [POWER_W-1:0] s4_power_reg;
    logic                      s4_manual_reg, s4_up_reg, s4_down_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_power_reg  <= power_sum;
            s4_manual_reg <= s3_manual_reg;
            s4_up_reg     <= s3_up_reg;
            s4_down_reg   <= s3_down_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: manual select or floor, offset removal, saturation.
    // Holding both buttons gives zero power.
    // ------------------------------------------------------------------
    logic signed [POWER_W-1:0] floor_ext, manual_power, power_sel, drive_wide;
    logic signed [DRIVE_W-1:0] drive_next;
    logic signed [DRIVE_W-1:0] drive_reg;

    assign floor_ext = {{(POWER_W-FLOOR_W){drive_floor_reg[FLOOR_W-1]}}, drive_floor_reg};

    always_comb begin
        if (s4_up_reg && !s4_down_reg) begin
            manual_power = MANUAL_STEP;
        end else if (s4_down_reg && !s4_up_reg) begin
            manual_power = -MANUAL_STEP;
        end else begin
            manual_power = '0;
        end

        if (s4_manual_reg) begin
            power_sel = manual_power;
        end else if (s4_power_reg < floor_ext) begin
            power_sel = floor_ext;
        end else begin
            power_sel = s4_power_reg;
        end

        drive_wide = power_sel - offs_ext;

        // The limits are widened as signed values so the compares stay signed.
        if (drive_wide > $signed({{(POWER_W-DRIVE_W){1'b0}}, DRIVE_MAX})) begin
            drive_next = DRIVE_MAX;
        end else if (drive_wide < $signed({{(POWER_W-DRIVE_W){1'b1}}, DRIVE_MIN})) begin
            drive_next = DRIVE_MIN;
        end else begin
            drive_next = drive_wide[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            drive_reg <= drive_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;

endmodule

/* hw/rtl/arm_pid_checker.sv */
`timescale 1ns / 1ps

module arm_pid_checker
    import arm_pid_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [DRIVE_W-1:0] m_tdata
);

    // A stalled result stays offered.
    a_out_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // With the result side held ready, an accepted tick reaches the output register and is offered.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind arm_position_pid_top arm_pid_checker u_arm_pid_checker (.*);
